[rtl/slls_pkg.sv]
package slls_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int SLOT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;

   localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(DEPTH);
   localparam logic [SLOT_W-1:0] FULL_COUNT = SLOT_W'(DEPTH);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_VALUE    = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

endpackage

[rtl/slls_ram.sv]
module slls_ram #(
   parameter int WIDTH = 32,
   parameter int ENTRIES = 64,
   parameter int ADDR_W = $clog2(ENTRIES)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [ENTRIES];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sorted_linked_list_store.sv]
// Insert: to S_EMIT when the store is empty or full, via S_INS_HEAD when the value
//   is the new head; else via S_INS_HEAD, S_INS_WALK per node, S_INS_LINK and S_INS_TAIL.
// Read out: one result per cycle while the receiver takes them (rsp_ready), one memory
//   read per list node. One item in flight; next item taken once the result is registered.
// Reset (synchronous): list empty, head null, no result pending. Node memories not cleared.
module sorted_linked_list_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic signed [slls_pkg::VAL_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [slls_pkg::VAL_W-1:0] rsp_item_value,
   output logic                              rsp_last_item,
   output logic [1:0]                        rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_HEAD,
      S_INS_WALK,
      S_INS_LINK,
      S_INS_TAIL,
      S_EMIT,
      S_RD_DATA
   } state_type;

   state_type                               state_ff, state_in;
   logic [slls_pkg::SLOT_W-1:0]             head_ff, head_in;
   logic [slls_pkg::SLOT_W-1:0]             used_ff, used_in;
   logic [slls_pkg::SLOT_W-1:0]             slot_ff, slot_in;
   logic signed [slls_pkg::VAL_W-1:0]       val_ff, val_in;
   logic [slls_pkg::IDX_W-1:0]              cur_ff, cur_in;
   logic [slls_pkg::SLOT_W-1:0]             nxt_ff, nxt_in;
   logic [slls_pkg::SLOT_W-1:0]             steps_ff, steps_in;
   slls_pkg::status_type                    pend_ff, pend_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [slls_pkg::VAL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                                    rsp_last_ff, rsp_last_in;
   slls_pkg::status_type                    rsp_status_ff, rsp_status_in;

   logic                                    val_wr_en;
   logic [slls_pkg::IDX_W-1:0]              val_wr_addr;
   logic [slls_pkg::VAL_W-1:0]              val_wr_data;
   logic                                    link_wr_en;
   logic [slls_pkg::IDX_W-1:0]              link_wr_addr;
   logic [slls_pkg::SLOT_W-1:0]             link_wr_data;
   logic                                    rd_en;
   logic [slls_pkg::IDX_W-1:0]              rd_addr;
   logic [slls_pkg::VAL_W-1:0]              val_rd;
   logic [slls_pkg::SLOT_W-1:0]             link_rd;

   logic                                    req_fire;
   logic                                    can_load;
   logic                                    rd_last;
   logic [slls_pkg::SLOT_W-1:0]             steps_inc;

   slls_ram #(
      .WIDTH   (slls_pkg::VAL_W),
      .ENTRIES (slls_pkg::DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   slls_ram #(
      .WIDTH   (slls_pkg::SLOT_W),
      .ENTRIES (slls_pkg::DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign can_load = !rsp_valid_ff || rsp_ready;
   assign steps_inc = steps_ff + slls_pkg::SLOT_W'(1);
   assign rd_last = (link_rd >= used_ff) || (steps_inc >= used_ff);

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      used_in = used_ff;
      slot_in = slot_ff;
      val_in = val_ff;
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      steps_in = steps_ff;
      pend_in = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      val_wr_en = 1'b0;
      val_wr_addr = slot_ff[slls_pkg::IDX_W-1:0];
      val_wr_data = val_ff;
      link_wr_en = 1'b0;
      link_wr_addr = slot_ff[slls_pkg::IDX_W-1:0];
      link_wr_data = nxt_ff;
      rd_en = 1'b0;
      rd_addr = nxt_ff[slls_pkg::IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_type == slls_pkg::REQ_INSERT) begin
                  if (used_ff >= slls_pkg::FULL_COUNT) begin
                     pend_in = slls_pkg::ST_FULL;
                     state_in = S_EMIT;
                  end else begin
                     val_wr_en = 1'b1;
                     val_wr_addr = used_ff[slls_pkg::IDX_W-1:0];
                     val_wr_data = req_value;
                     slot_in = used_ff;
                     val_in = req_value;
                     used_in = used_ff + slls_pkg::SLOT_W'(1);
                     if (head_ff >= used_ff) begin
                        link_wr_en = 1'b1;
                        link_wr_addr = used_ff[slls_pkg::IDX_W-1:0];
                        link_wr_data = slls_pkg::NULL_SLOT;
                        head_in = used_ff;
                        pend_in = slls_pkg::ST_INSERTED;
                        state_in = S_EMIT;
                     end else begin
                        rd_en = 1'b1;
                        rd_addr = head_ff[slls_pkg::IDX_W-1:0];
                        state_in = S_INS_HEAD;
                     end
                  end
               end else begin
                  if (used_ff == '0 || head_ff >= used_ff) begin
                     pend_in = slls_pkg::ST_EMPTY;
                     state_in = S_EMIT;
                  end else begin
                     rd_en = 1'b1;
                     rd_addr = head_ff[slls_pkg::IDX_W-1:0];
                     steps_in = '0;
                     state_in = S_RD_DATA;
                  end
               end
            end
         end
         S_INS_HEAD: begin
            if (val_ff <= $signed(val_rd)) begin
               link_wr_en = 1'b1;
               link_wr_data = head_ff;
               head_in = slot_ff;
               pend_in = slls_pkg::ST_INSERTED;
               state_in = S_EMIT;
            end else begin
               cur_in = head_ff[slls_pkg::IDX_W-1:0];
               nxt_in = link_rd;
               steps_in = '0;
               if (link_rd >= slot_ff) begin
                  state_in = S_INS_LINK;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = link_rd[slls_pkg::IDX_W-1:0];
                  state_in = S_INS_WALK;
               end
            end
         end
         S_INS_WALK: begin
            if ($signed(val_rd) > val_ff) begin
               state_in = S_INS_LINK;
            end else begin
               cur_in = nxt_ff[slls_pkg::IDX_W-1:0];
               nxt_in = link_rd;
               steps_in = steps_inc;
               if (link_rd >= slot_ff || steps_inc >= slot_ff) begin
                  state_in = S_INS_LINK;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = link_rd[slls_pkg::IDX_W-1:0];
               end
            end
         end
         S_INS_LINK: begin
            link_wr_en = 1'b1;
            link_wr_addr = cur_ff;
            link_wr_data = slot_ff;
            state_in = S_INS_TAIL;
         end
         S_INS_TAIL: begin
            link_wr_en = 1'b1;
            link_wr_data = nxt_ff;
            pend_in = slls_pkg::ST_INSERTED;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in = 1'b1;
               rsp_status_in = pend_ff;
               state_in = S_IDLE;
            end
         end
         S_RD_DATA: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = val_rd;
               rsp_last_in = rd_last;
               rsp_status_in = slls_pkg::ST_VALUE;
               if (rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = link_rd[slls_pkg::IDX_W-1:0];
                  steps_in = steps_inc;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= slls_pkg::NULL_SLOT;
         used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff <= slot_in;
      val_ff <= val_in;
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      steps_ff <= steps_in;
      pend_ff <= pend_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item_value = rsp_value_ff;
   assign rsp_last_item = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

endmodule

[tb/sv/sorted_linked_list_store_tb.sv]
`timescale 1ns / 100ps

module sorted_linked_list_store_tb;
   import slls_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int TOTAL_ITEMS = 350;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [VAL_W-1:0] item_value;
      logic                    last_item;
      status_type              status;
   } list_output_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = REQ_INSERT;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_item_value;
   logic                    rsp_last_item;
   logic [1:0]              rsp_status;

   // list shadow
   logic signed [VAL_W-1:0] node_value [DEPTH];
   int                      node_link [DEPTH];
   int                      head_node = DEPTH;
   int                      node_count = 0;

   list_output_type pending_outputs[$];
   int error_count = 0;
   int idle_cycles = 0;
   int items_sent = 0;
   int inserts_sent = 0;
   int hold_request = 0;
   bit steady = 1'b0;

   sorted_linked_list_store i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_value (rsp_item_value),
      .rsp_last_item  (rsp_last_item),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void push_output(logic signed [VAL_W-1:0] v, logic last,
                                       status_type st);
      list_output_type o;
      o.item_value = v;
      o.last_item = last;
      o.status = st;
      pending_outputs.push_back(o);
   endfunction

   function automatic void predict_list_outputs(logic kind, logic signed [VAL_W-1:0] val);
      int slot;
      int cur;
      int nxt;
      int steps;
      int k;
      bit done;
      if (kind == REQ_INSERT) begin
         if (node_count >= DEPTH) begin
            push_output('0, 1'b1, ST_FULL);
         end else begin
            slot = node_count;
            node_value[slot] = val;
            node_count++;
            if (head_node >= slot) begin
               node_link[slot] = DEPTH;
               head_node = slot;
            end else if (val <= node_value[head_node]) begin
               node_link[slot] = head_node;
               head_node = slot;
            end else begin
               cur = head_node;
               steps = 0;
               done = 1'b0;
               while (!done) begin
                  nxt = node_link[cur];
                  if (nxt >= slot || steps >= slot) begin
                     done = 1'b1;
                  end else if (node_value[nxt] > val) begin
                     done = 1'b1;
                  end else begin
                     cur = nxt;
                     steps++;
                  end
               end
               node_link[slot] = node_link[cur];
               node_link[cur] = slot;
            end
            push_output('0, 1'b1, ST_INSERTED);
         end
      end else begin
         if (node_count == 0 || head_node >= node_count) begin
            push_output('0, 1'b1, ST_EMPTY);
         end else begin
            cur = head_node;
            k = 0;
            done = 1'b0;
            while (!done) begin
               nxt = node_link[cur];
               done = (nxt >= node_count) || (k + 1 >= node_count);
               push_output(node_value[cur], done, ST_VALUE);
               k++;
               cur = nxt;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_list_outputs(req_type, req_value);
      end
   end

   always @(posedge clock) begin
      list_output_type exp_out;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected item: value %0d last %0b status %0d",
                        rsp_item_value, rsp_last_item, rsp_status);
            end
         end else begin
            exp_out = pending_outputs.pop_front();
            if (rsp_item_value !== exp_out.item_value || rsp_last_item !== exp_out.last_item
                || rsp_status !== exp_out.status) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("mismatch: exp value %0d last %0b status %0d, got %0d %0b %0d",
                           exp_out.item_value, exp_out.last_item, exp_out.status,
                           rsp_item_value, rsp_last_item, rsp_status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            gap = hold_request;
            hold_request = 0;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 4);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_item(input logic kind, input logic signed [VAL_W-1:0] val);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type <= kind;
      req_value <= val;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (kind == REQ_INSERT) inserts_sent++;
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 16)) - 8;
         2: begin
            case ($urandom_range(0, 3))
               0: return VAL_MAX;
               1: return VAL_MIN;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return VAL_MAX - $urandom_range(0, 3);
      endcase
   endfunction

   task automatic test_empty_read();
      send_item(REQ_READ, $urandom);
   endtask

   task automatic test_directed_inserts();
      send_item(REQ_INSERT, 0);
      send_item(REQ_INSERT, 100);
      send_item(REQ_INSERT, -5);
      send_item(REQ_INSERT, -5);
      send_item(REQ_INSERT, 100);
      send_item(REQ_INSERT, 50);
      send_item(REQ_INSERT, VAL_MAX);
      send_item(REQ_INSERT, VAL_MIN);
      send_item(REQ_INSERT, VAL_MAX);
      send_item(REQ_INSERT, 0);
      send_item(REQ_INSERT, -1);
      send_item(REQ_READ, '1);
   endtask

   task automatic test_random_fill();
      int n;
      n = 0;
      while (inserts_sent < DEPTH) begin
         if (n % 16 == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) send_item(REQ_READ, $urandom);
         else send_item(REQ_INSERT, pick_value());
         n++;
      end
      steady = 1'b0;
      send_item(REQ_READ, $urandom);
   endtask

   task automatic test_full_store();
      send_item(REQ_INSERT, VAL_MIN);
      send_item(REQ_INSERT, VAL_MAX);
      send_item(REQ_INSERT, 0);
      send_item(REQ_READ, 0);
   endtask

   task automatic test_receiver_hold();
      steady = 1'b1;
      hold_request = HOLD_CYCLES;
      repeat (6) send_item(1'($urandom_range(0, 1)), $urandom);
      steady = 1'b0;
   endtask

   task automatic test_random_mix();
      int n;
      n = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (n % 16 == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 4) send_item(REQ_READ, $urandom);
         else send_item(REQ_INSERT, pick_value());
         n++;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_read();
      test_directed_inserts();
      test_random_fill();
      test_full_store();
      test_receiver_hold();
      test_random_mix();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0 && pending_outputs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
rtl/slls_pkg.sv
rtl/slls_ram.sv
rtl/sorted_linked_list_store.sv
tb/sv/sorted_linked_list_store_tb.sv
